// ===== hdl/bvp_pkg.sv =====
// shared constants, types and control structs of the battery percent converter
package bvp_pkg;

  localparam int MV_W      = 16;
  localparam int PCT_W     = 7;
  localparam int IDX_W     = 4;
  localparam int PTS_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int NUM_W     = MV_W + PCT_W;
  localparam int STEP_W    = $clog2(PCT_W);

  localparam int CURVE_DEPTH_DEF = 16;
  localparam int MV_BITS_DEF     = 16;
  localparam int MIN_POINTS      = 2;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [MV_W-1:0]  EMPTY_RST  = 16'd3300;
  localparam logic [MV_W-1:0]  FULL_RST   = 16'd4200;
  localparam logic [PTS_W-1:0] POINTS_RST = 5'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd2;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_TABLE,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic              wr;
    logic              latch;
    logic              ld_lo;
    logic              ld_seg;
    logic              ld_lin;
    logic              ld_mul;
    logic              div_en;
    logic [STEP_W-1:0] step;
    logic              ld_pend;
    res_sel_e          pend_sel;
    logic              pend_used;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic le;
    logic ge;
    logic lin_zero;
    logic lin_full;
  } sts_t;

endpackage

// ===== hdl/bvp_ifs.sv =====
// valid/ready channel interfaces for input items and result items
interface bvp_in_if import bvp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [MV_W-1:0]  millivolts;
  logic [IDX_W-1:0] point_index;
  logic [MV_W-1:0]  point_millivolts;
  logic [PCT_W-1:0] point_percent;

  modport source (
    output valid, op, millivolts, point_index, point_millivolts, point_percent,
    input  ready
  );
  modport sink (
    input  valid, op, millivolts, point_index, point_millivolts, point_percent,
    output ready
  );
endinterface

interface bvp_out_if import bvp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] percent;
  logic             used_curve;

  modport source (
    output valid, percent, used_curve,
    input  ready
  );
  modport sink (
    input  valid, percent, used_curve,
    output ready
  );
endinterface

// ===== hdl/bvp_ram.sv =====
// generic single write port, single read port ram with registered read
module bvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bvp_ctrl.sv =====
// controller fsm: segment search, multiply and divide sequencing, result hand-off
module bvp_ctrl import bvp_pkg::*; #(
  parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_op_i,
  output logic                           in_ready_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  input  logic [PTS_W-1:0]               points_i,
  input  sts_t                           sts_i,
  output cmd_t                           cmd_o,
  output logic [$clog2(CURVE_DEPTH)-1:0] rd_addr_o
);

  localparam int AW = $clog2(CURVE_DEPTH);
  localparam int CW = ($clog2(CURVE_DEPTH + 1) > PTS_W) ? $clog2(CURVE_DEPTH + 1) : PTS_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIRST  = 4'd1;
  localparam logic [3:0] S_LAST   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_LIN    = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_INTERP = 4'd7;
  localparam logic [3:0] S_PUT    = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              curve_q, curve_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     pts_ext, n_eff;
  logic [AW-1:0]     last_addr;
  logic              use_curve;
  logic              accept;

  // points beyond the table depth are clamped to it
  assign pts_ext   = CW'(points_i);
  assign n_eff     = (pts_ext > CW'(CURVE_DEPTH)) ? CW'(CURVE_DEPTH) : pts_ext;
  assign last_addr = AW'(n_eff - CW'(1));
  assign use_curve = (n_eff >= CW'(MIN_POINTS));

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    step_d        = step_q;
    curve_d       = curve_q;
    cmd_o         = '0;
    cmd_o.pend_sel = RES_ZERO;
    rd_addr_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        // entry 0 is fetched speculatively for the clamp check
        rd_addr_o = '0;
        if (accept) begin
          cmd_o.latch = 1'b1;
          if (in_op_i == OP_LOAD) begin
            cmd_o.wr        = 1'b1;
            cmd_o.ld_pend   = 1'b1;
            cmd_o.pend_sel  = RES_ZERO;
            cmd_o.pend_used = 1'b0;
            state_d         = S_PUT;
          end else if (use_curve) begin
            curve_d = 1'b1;
            state_d = S_FIRST;
          end else begin
            curve_d = 1'b0;
            state_d = S_LIN;
          end
        end
      end
      S_FIRST: begin
        rd_addr_o   = last_addr;
        cmd_o.ld_lo = 1'b1;
        if (sts_i.le) begin
          cmd_o.ld_pend   = 1'b1;
          cmd_o.pend_sel  = RES_TABLE;
          cmd_o.pend_used = 1'b1;
          state_d         = S_PUT;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr_o = AW'(1);
        cnt_d     = AW'(1);
        if (sts_i.ge) begin
          cmd_o.ld_pend   = 1'b1;
          cmd_o.pend_sel  = RES_TABLE;
          cmd_o.pend_used = 1'b1;
          state_d         = S_PUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // one table entry per cycle; the last entry is known to end the search
        rd_addr_o = cnt_q + AW'(1);
        if (sts_i.le) begin
          cmd_o.ld_seg = 1'b1;
          state_d      = S_MUL;
        end else begin
          cmd_o.ld_lo = 1'b1;
          cnt_d       = cnt_q + AW'(1);
        end
      end
      S_LIN: begin
        if (sts_i.lin_zero) begin
          cmd_o.ld_pend   = 1'b1;
          cmd_o.pend_sel  = RES_ZERO;
          cmd_o.pend_used = 1'b0;
          state_d         = S_PUT;
        end else if (sts_i.lin_full) begin
          cmd_o.ld_pend   = 1'b1;
          cmd_o.pend_sel  = RES_FULL;
          cmd_o.pend_used = 1'b0;
          state_d         = S_PUT;
        end else begin
          cmd_o.ld_lin = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.ld_mul = 1'b1;
        step_d       = STEP_W'(PCT_W - 1);
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        cmd_o.step   = step_q;
        if (step_q == '0) begin
          state_d = S_INTERP;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_INTERP: begin
        cmd_o.ld_pend   = 1'b1;
        cmd_o.pend_sel  = RES_INTERP;
        cmd_o.pend_used = curve_q;
        state_d         = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      curve_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      curve_q     <= curve_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/bvp_dp.sv =====
// datapath: curve table, segment registers, multiplier, restoring divider, result regs
module bvp_dp import bvp_pkg::*; #(
  parameter int CURVE_DEPTH = CURVE_DEPTH_DEF,
  parameter int MV_BITS     = MV_BITS_DEF
) (
  input  logic                           clk_i,
  input  cmd_t                           cmd_i,
  output sts_t                           sts_o,
  input  logic [$clog2(CURVE_DEPTH)-1:0] rd_addr_i,
  input  logic [MV_W-1:0]                millivolts_i,
  input  logic [IDX_W-1:0]               point_index_i,
  input  logic [MV_W-1:0]                point_millivolts_i,
  input  logic [PCT_W-1:0]               point_percent_i,
  input  logic [MV_W-1:0]                empty_i,
  input  logic [MV_W-1:0]                full_i,
  output logic [PCT_W-1:0]               percent_o,
  output logic                           used_curve_o
);

  localparam int AW = $clog2(CURVE_DEPTH);
  localparam int VW = (MV_BITS < MV_W) ? MV_BITS : MV_W;
  localparam int RW = VW + PCT_W;

  logic [MV_W-1:0]  mv_q, lo_q, span_q;
  logic [PCT_W-1:0] plo_q, mag_q, quo_q, pend_pct_q, pct_q;
  logic             neg_q, pend_used_q, used_q;
  logic [NUM_W-1:0] rem_q;

  logic             idx_ok, ram_we;
  logic [RW-1:0]    wdata, rdata;
  logic [MV_W-1:0]  rd_v, diff;
  logic [PCT_W-1:0] rd_p, pp_sat, interp, pend_pct;
  logic [NUM_W-1:0] shifted;
  logic             fits;

  assign idx_ok = (32'(point_index_i) < 32'(CURVE_DEPTH));
  assign ram_we = cmd_i.wr && idx_ok;
  assign pp_sat = (point_percent_i > PCT_MAX) ? PCT_MAX : point_percent_i;
  assign wdata  = {point_millivolts_i[VW-1:0], pp_sat};

  bvp_ram #(
    .WIDTH (RW),
    .DEPTH (CURVE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(point_index_i)),
    .wdata_i (wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign rd_v = MV_W'(rdata[RW-1:PCT_W]);
  assign rd_p = rdata[PCT_W-1:0];

  assign sts_o.le       = (mv_q <= rd_v);
  assign sts_o.ge       = (mv_q >= rd_v);
  assign sts_o.lin_zero = (full_i <= empty_i) || (mv_q <= empty_i);
  assign sts_o.lin_full = (mv_q >= full_i);

  // mv is above lo whenever the product is formed, so diff stays positive
  assign diff    = mv_q - lo_q;
  assign shifted = NUM_W'(span_q) << cmd_i.step;
  assign fits    = (rem_q >= shifted);
  assign interp  = neg_q ? (plo_q - quo_q) : (plo_q + quo_q);

  always_comb begin
    unique case (cmd_i.pend_sel)
      RES_ZERO:   pend_pct = '0;
      RES_FULL:   pend_pct = PCT_MAX;
      RES_TABLE:  pend_pct = rd_p;
      RES_INTERP: pend_pct = interp;
      default:    pend_pct = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mv_q <= MV_W'(millivolts_i[VW-1:0]);
    end
    if (cmd_i.ld_lo) begin
      lo_q  <= rd_v;
      plo_q <= rd_p;
    end
    if (cmd_i.ld_seg) begin
      span_q <= rd_v - lo_q;
      neg_q  <= (rd_p < plo_q);
      mag_q  <= (rd_p < plo_q) ? (plo_q - rd_p) : (rd_p - plo_q);
    end
    if (cmd_i.ld_lin) begin
      lo_q   <= empty_i;
      plo_q  <= '0;
      span_q <= full_i - empty_i;
      neg_q  <= 1'b0;
      mag_q  <= PCT_MAX;
    end
    if (cmd_i.ld_mul) begin
      rem_q <= NUM_W'(diff) * NUM_W'(mag_q);
      quo_q <= '0;
    end
    // one quotient bit per cycle, msb first
    if (cmd_i.div_en && fits) begin
      rem_q              <= rem_q - shifted;
      quo_q[cmd_i.step] <= 1'b1;
    end
    if (cmd_i.ld_pend) begin
      pend_pct_q  <= pend_pct;
      pend_used_q <= cmd_i.pend_used;
    end
    if (cmd_i.out_load) begin
      pct_q  <= pend_pct_q;
      used_q <= pend_used_q;
    end
  end

  assign percent_o    = pct_q;
  assign used_curve_o = used_q;

endmodule

// ===== hdl/battery_voltage_to_percent.sv =====
// top level of the battery voltage to charge percent converter
//
// Input items arrive on in_if (valid/ready). op selects convert (measure
// millivolts) or load (write one curve point into the table). Every item gives
// exactly one result item on out_if: percent and used_curve, zeros for a load.
// Configuration registers (empty, full, curve point count) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no item
// is in flight, and the block does not enforce this. One item is in work at a
// time; in_if.ready is high only while the fsm idles. Result paths on out_if:
//   load item
//   curve mode, clamped to the first point or to the last point
//   curve mode, interpolated on segment k (1-based)
//   linear mode, clamped or scaled
// The table scan reads one entry per cycle through the ram read port, and
// interpolated and scaled results pass the 7-step restoring divider; the
// next item is accepted the cycle after the result is registered. A stalled
// result sits in the output register while the next item is worked on; that
// item then waits until the result is taken. Reset clears the fsm and the
// config registers; the curve table is not cleared and holds garbage until loaded.
module battery_voltage_to_percent import bvp_pkg::*; #(
  parameter int CURVE_DEPTH = CURVE_DEPTH_DEF,
  parameter int MV_BITS     = MV_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bvp_in_if.sink               in_if,
  bvp_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [MV_W-1:0]  empty_q, empty_d;
  logic [MV_W-1:0]  full_q, full_d;
  logic [PTS_W-1:0] points_q, points_d;

  cmd_t cmd;
  sts_t sts;
  logic [$clog2(CURVE_DEPTH)-1:0] rd_addr;

  always_comb begin
    empty_d  = empty_q;
    full_d   = full_q;
    points_d = points_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EMPTY:  empty_d  = cfg_data_i[MV_W-1:0];
        CFG_FULL:   full_d   = cfg_data_i[MV_W-1:0];
        CFG_POINTS: points_d = cfg_data_i[PTS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q  <= EMPTY_RST;
      full_q   <= FULL_RST;
      points_q <= POINTS_RST;
    end else begin
      empty_q  <= empty_d;
      full_q   <= full_d;
      points_q <= points_d;
    end
  end

  bvp_ctrl #(
    .CURVE_DEPTH (CURVE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.op),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .points_i    (points_q),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  bvp_dp #(
    .CURVE_DEPTH (CURVE_DEPTH),
    .MV_BITS     (MV_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rd_addr_i          (rd_addr),
    .millivolts_i       (in_if.millivolts),
    .point_index_i      (in_if.point_index),
    .point_millivolts_i (in_if.point_millivolts),
    .point_percent_i    (in_if.point_percent),
    .empty_i            (empty_q),
    .full_i             (full_q),
    .percent_o          (out_if.percent),
    .used_curve_o       (out_if.used_curve)
  );

`ifndef ASSERT_OFF
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.percent <= PCT_MAX))
    else $error("result percent above 100");

  a_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> (in_if.valid && in_if.ready && (in_if.op == OP_LOAD)))
    else $error("table write without an accepted load item");

  a_curve_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.used_curve) |-> (points_q >= PTS_W'(MIN_POINTS)))
    else $error("curve result while fewer than two points are in use");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second item accepted while one is in work");
`endif

endmodule

// ===== tb/tb_battery_voltage_to_percent.sv =====
// testbench: directed rows, then random curve/linear phases, each result checked in order
`timescale 1ns / 1ps

module tb_battery_voltage_to_percent;
  import bvp_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int LATENCY_PAD   = 40;
  localparam int N_PLAN        = 35;
  localparam int N_PHASES      = 20;
  localparam int PHASE_ITEMS   = 90;
  localparam int MAX_PRINTED   = 50;

  typedef struct packed {
    logic             op;
    logic [MV_W-1:0]  mv;
    logic [IDX_W-1:0] idx;
    logic [MV_W-1:0]  point_mv;
    logic [PCT_W-1:0] point_pct;
  } volt_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             used_curve;
  } charge_reading_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    volt_item_t           item;
    logic                 fixed_want;
    charge_reading_t      want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bvp_in_if  in_ch ();
  bvp_out_if out_ch ();

  battery_voltage_to_percent DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [MV_W-1:0]  set_empty_mv = EMPTY_RST;
  logic [MV_W-1:0]  set_full_mv  = FULL_RST;
  logic [PTS_W-1:0] set_points   = POINTS_RST;
  logic [MV_W-1:0]  tbl_mv  [CURVE_DEPTH_DEF];
  logic [PCT_W-1:0] tbl_pct [CURVE_DEPTH_DEF];

  charge_reading_t pending_readings [$];
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  bit              steady = 1'b0;
  plan_row_t       plan [N_PLAN];

  initial begin
    for (int k = 0; k < CURVE_DEPTH_DEF; k++) begin
      tbl_mv[k]  = '0;
      tbl_pct[k] = '0;
    end
  end

  function automatic int curve_len();
    if (set_points > PTS_W'(CURVE_DEPTH_DEF)) return CURVE_DEPTH_DEF;
    return int'(set_points);
  endfunction

  function automatic logic [PCT_W-1:0] curve_percent(logic [MV_W-1:0] mv, int n);
    longint lo, hi, plo, phi, r;
    if (mv <= tbl_mv[0]) return tbl_pct[0];
    if (mv >= tbl_mv[n-1]) return tbl_pct[n-1];
    // first segment whose upper voltage reaches the measurement
    for (int i = 0; i + 1 < n; i++) begin
      if (mv <= tbl_mv[i+1]) begin
        lo  = longint'(tbl_mv[i]);
        hi  = longint'(tbl_mv[i+1]);
        plo = longint'(tbl_pct[i]);
        phi = longint'(tbl_pct[i+1]);
        if (hi - lo <= 0) return tbl_pct[i];
        r = plo + (longint'(mv) - lo) * (phi - plo) / (hi - lo);
        if (r < 0) r = 0;
        if (r > longint'(PCT_MAX)) r = longint'(PCT_MAX);
        return PCT_W'(r);
      end
    end
    return tbl_pct[n-1];
  endfunction

  function automatic logic [PCT_W-1:0] linear_percent(logic [MV_W-1:0] mv);
    longint span;
    if (set_full_mv <= set_empty_mv || mv <= set_empty_mv) return '0;
    if (mv >= set_full_mv) return PCT_MAX;
    span = longint'(set_full_mv) - longint'(set_empty_mv);
    return PCT_W'((longint'(mv) - longint'(set_empty_mv)) * longint'(PCT_MAX) / span);
  endfunction

  // next reading for one accepted item; load items update the curve table
  function automatic charge_reading_t predict_reading(volt_item_t it);
    charge_reading_t res;
    int              n;
    res = '0;
    if (it.op == OP_LOAD) begin
      tbl_mv[it.idx]  = it.point_mv;
      tbl_pct[it.idx] = (it.point_pct > PCT_MAX) ? PCT_MAX : it.point_pct;
    end else begin
      n = curve_len();
      if (n >= MIN_POINTS) begin
        res.percent    = curve_percent(it.mv, n);
        res.used_curve = 1'b1;
      end else begin
        res.percent = linear_percent(it.mv);
      end
    end
    return res;
  endfunction

  function automatic plan_row_t row_cv(logic [MV_W-1:0] mv);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_ITEM;
    r.item.op = OP_CONVERT;
    r.item.mv = mv;
    return r;
  endfunction

  function automatic plan_row_t row_cvk(logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct,
                                        logic used);
    plan_row_t r;
    r                 = row_cv(mv);
    r.fixed_want      = 1'b1;
    r.want.percent    = pct;
    r.want.used_curve = used;
    return r;
  endfunction

  function automatic plan_row_t row_ld(logic [IDX_W-1:0] idx, logic [MV_W-1:0] pmv,
                                       logic [PCT_W-1:0] ppct);
    plan_row_t r;
    r                = '0;
    r.kind           = ROW_ITEM;
    r.item.op        = OP_LOAD;
    r.item.idx       = idx;
    r.item.point_mv  = pmv;
    r.item.point_pct = ppct;
    r.fixed_want     = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_EMPTY:  set_empty_mv = val[MV_W-1:0];
      CFG_FULL:   set_full_mv  = val[MV_W-1:0];
      CFG_POINTS: set_points   = val[PTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drive_item(input volt_item_t it, input logic fixed_want,
                            input charge_reading_t want);
    int unsigned     gap;
    charge_reading_t predicted;
    gap = steady ? 0 : $urandom_range(0, 3);
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.op               <= it.op;
    in_ch.millivolts       <= it.mv;
    in_ch.point_index      <= it.idx;
    in_ch.point_millivolts <= it.point_mv;
    in_ch.point_percent    <= it.point_pct;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = predict_reading(it);
    pending_readings.push_back(fixed_want ? want : predicted);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // well-formed curve: rising voltages, mostly rising percents, some above 100
  task automatic load_rising_curve();
    volt_item_t it;
    int unsigned v, p;
    v = $urandom_range(0, 4000);
    p = $urandom_range(0, 20);
    for (int k = 0; k < CURVE_DEPTH_DEF; k++) begin
      it.op        = OP_LOAD;
      it.mv        = MV_W'($urandom);
      it.idx       = IDX_W'(k);
      it.point_mv  = MV_W'(v);
      it.point_pct = PCT_W'((p > 127) ? 127 : p);
      drive_item(it, 1'b0, '0);
      v += $urandom_range(0, 4000);
      p += $urandom_range(0, 12);
    end
  endtask

  function automatic logic [MV_W-1:0] pick_millivolts();
    logic [MV_W-1:0] lo, hi;
    int unsigned     k;
    k = $urandom_range(0, CURVE_DEPTH_DEF - 1);
    if (curve_len() >= MIN_POINTS) begin
      lo = tbl_mv[0];
      hi = tbl_mv[curve_len() - 1];
    end else begin
      lo = set_empty_mv;
      hi = set_full_mv;
    end
    case ($urandom_range(0, 5))
      0:       return MV_W'($urandom);
      1:       return tbl_mv[k] + MV_W'($urandom_range(0, 4)) - MV_W'(2);
      2, 3:    return MV_W'($urandom_range(32'(lo), 32'(hi)));
      4:       return ($urandom_range(0, 1) != 0 ? lo : hi) + MV_W'($urandom_range(0, 2))
                      - MV_W'(1);
      default: return ($urandom_range(0, 1) != 0) ? '0 : '1;
    endcase
  endfunction

  function automatic volt_item_t random_item();
    volt_item_t it;
    it.op        = ($urandom_range(0, 99) < 15) ? OP_LOAD : OP_CONVERT;
    it.mv        = pick_millivolts();
    it.idx       = IDX_W'($urandom);
    it.point_mv  = MV_W'($urandom);
    it.point_pct = PCT_W'($urandom);
    return it;
  endfunction

  task automatic pick_settings(input int ph);
    logic [MV_W-1:0]  e, f;
    logic [PTS_W-1:0] pts;
    logic [CFG_W-1:0] pts_word;
    case ($urandom_range(0, 6))
      0: begin e = '0; f = '1; end
      1: begin e = '1; f = '0; end
      2: begin e = MV_W'($urandom); f = e; end
      3: begin e = MV_W'($urandom); f = MV_W'($urandom); end
      default: begin
        e = MV_W'($urandom_range(2500, 3600));
        f = e + MV_W'($urandom_range(1, 1500));
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: pts = PTS_W'($urandom_range(0, 1));
      8, 9:    pts = PTS_W'($urandom_range(17, 31));
      default: pts = PTS_W'($urandom_range(2, 16));
    endcase
    // make sure the table size extremes come up early
    if (ph == 1) pts = PTS_W'(CURVE_DEPTH_DEF);
    if (ph == 2) pts = PTS_W'(MIN_POINTS);
    if (ph == 3) pts = '1;
    pts_word = CFG_W'($urandom);
    pts_word[PTS_W-1:0] = pts;
    write_reg(CFG_EMPTY, e);
    write_reg(CFG_FULL, f);
    write_reg(CFG_POINTS, pts_word);
  endtask

  task automatic check_reading(input logic [PCT_W-1:0] pct, input logic used);
    charge_reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch($sformatf("result percent %0d used_curve %0d with none pending",
                                pct, used));
      return;
    end
    want = pending_readings.pop_front();
    if (pct !== want.percent)
      report_mismatch($sformatf("percent %0d, expected %0d", pct, want.percent));
    if (used !== want.used_curve)
      report_mismatch($sformatf("used_curve %0d, expected %0d", used, want.used_curve));
  endtask

  // result side: random stall per item, ready held until the item is taken
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      check_reading(out_ch.percent, out_ch.used_curve);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    bit in_flight;
    in_flight = 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.op               <= OP_CONVERT;
    in_ch.millivolts       <= '0;
    in_ch.point_index      <= '0;
    in_ch.point_millivolts <= '0;
    in_ch.point_percent    <= '0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CFG_EMPTY;
    cfg_data_i             <= '0;

    plan = '{
      // linear mode straight out of reset
      row_cvk(16'd0, 7'd0, 1'b0),
      row_cvk(16'd3300, 7'd0, 1'b0),
      row_cvk(16'd3750, 7'd50, 1'b0),
      row_cvk(16'd4200, 7'd100, 1'b0),
      row_cvk(16'd65535, 7'd100, 1'b0),
      row_cv(16'd3301),
      // small curve with a flat step and a saturating percent
      row_ld(4'd0, 16'd1000, 7'd10),
      row_ld(4'd1, 16'd2000, 7'd90),
      row_ld(4'd2, 16'd2000, 7'd40),
      row_ld(4'd3, 16'd3000, 7'd127),
      row_ld(4'd15, 16'd65535, 7'd0),
      row_cfg(CFG_POINTS, 16'd4),
      row_cvk(16'd0, 7'd10, 1'b1),
      row_cvk(16'd1000, 7'd10, 1'b1),
      row_cv(16'd1500),
      row_cvk(16'd2000, 7'd90, 1'b1),
      row_cv(16'd2500),
      row_cvk(16'd3000, 7'd100, 1'b1),
      row_cvk(16'd65535, 7'd100, 1'b1),
      // falling percent on a segment, truncation toward zero
      row_ld(4'd2, 16'd2500, 7'd0),
      row_cv(16'd2001),
      row_cv(16'd2250),
      // back to linear mode, full not above empty, then the widest span
      row_cfg(CFG_POINTS, 16'd1),
      row_cfg(CFG_EMPTY, 16'd4200),
      row_cfg(CFG_FULL, 16'd4200),
      row_cvk(16'd4200, 7'd0, 1'b0),
      row_cfg(CFG_EMPTY, 16'd65535),
      row_cfg(CFG_FULL, 16'd0),
      row_cvk(16'd65535, 7'd0, 1'b0),
      row_cfg(CFG_EMPTY, 16'd0),
      row_cfg(CFG_FULL, 16'd65535),
      row_cvk(16'd65535, 7'd100, 1'b0),
      row_cvk(16'd0, 7'd0, 1'b0),
      row_cv(16'd32768),
      row_cv(16'd1)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_PLAN; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        if (in_flight) begin
          drain_results();
          in_flight = 1'b0;
        end
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        drive_item(plan[r].item, plan[r].fixed_want, plan[r].want);
        in_flight = 1'b1;
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      pick_settings(ph);
      steady = ($urandom_range(0, 3) == 0);
      // the first phase fills every slot before any curve read can happen
      if (ph == 0 || $urandom_range(0, 2) == 0) load_rising_curve();
      for (int k = 0; k < PHASE_ITEMS; k++) drive_item(random_item(), 1'b0, '0);
    end

    steady = 1'b0;
    drain_results();
    repeat (LATENCY_PAD) @(posedge clk_i);
    if (pending_readings.size() != 0) report_mismatch("results still pending at end");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
